FILE: rtl/mbp_pkg.sv
`default_nettype none

package mbp_pkg;

    localparam int CodeW  = 80;
    localparam int LenW   = 7;
    localparam int MaxRaw = 64;

    localparam logic [1:0] OP_RAW   = 2'd0;
    localparam logic [1:0] OP_VLU8  = 2'd1;
    localparam logic [1:0] OP_VLU4  = 2'd2;
    localparam logic [1:0] OP_FLUSH = 2'd3;

    typedef struct packed {
        logic              flush;
        logic [LenW-1:0]   len;
        logic [CodeW-1:0]  bits;
    } t_code;

endpackage

`default_nettype wire

FILE: rtl/mbp_front.sv
`default_nettype none

module mbp_front (
    input  wire logic [1:0]  i_op,
    input  wire logic [63:0] i_value,
    input  wire logic [6:0]  i_bit_count,
    output mbp_pkg::t_code   o_code
);
    import mbp_pkg::*;

    logic [69:0]      vx;
    logic [3:0]       groups;
    logic [4:0]       nibs;
    logic [CodeW-1:0] word;
    logic [CodeW-1:0] ones;
    logic [LenW-1:0]  len;
    logic [6:0]       nib_bits;

    assign vx = {6'd0, i_value};

    always_comb begin
        groups = 4'd1;
        for (int i = 1; i < 10; i++) begin
            if ((vx >> (7 * i)) != 70'd0) begin
                groups = 4'(i + 1);
            end
        end
        nibs = 5'd1;
        for (int i = 1; i < 16; i++) begin
            if ((i_value >> (4 * i)) != 64'd0) begin
                nibs = 5'(i + 1);
            end
        end
    end

    assign nib_bits = {nibs, 2'b00};
    assign ones = ((CodeW'(1) << (nibs - 5'd1)) - CodeW'(1)) << (nib_bits + 7'd1);

    always_comb begin
        word = '0;
        len  = '0;
        case (i_op)
            OP_RAW: begin
                word = CodeW'(i_value);
                len  = (i_bit_count > 7'(MaxRaw)) ? 7'(MaxRaw) : i_bit_count;
            end
            OP_VLU8: begin
                for (int i = 0; i < 10; i++) begin
                    word[8*i +: 8] = {(i != 0), vx[7*i +: 7]};
                end
                len = {groups, 3'b000};
            end
            OP_VLU4: begin
                word = CodeW'(i_value) | ones;
                len  = nib_bits + 7'(nibs);
            end
            default: begin
                word = '0;
                len  = '0;
            end
        endcase
    end

    assign o_code.flush = (i_op == OP_FLUSH);
    assign o_code.len   = len;
    assign o_code.bits  = word << (7'(CodeW) - len);

endmodule

`default_nettype wire

FILE: rtl/mbp_queue.sv
`default_nettype none

module mbp_queue (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_push,
    input  wire mbp_pkg::t_code i_code,
    output logic             o_full,
    input  wire logic        i_pop,
    output logic             o_empty,
    output mbp_pkg::t_code   o_code
);
    import mbp_pkg::*;

    t_code      r_mem [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;
    logic       n_wr_ptr;
    logic       n_rd_ptr;
    logic [1:0] n_count;
    logic       do_push;
    logic       do_pop;

    assign o_full  = (r_count == 2'd2);
    assign o_empty = (r_count == 2'd0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_code  = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr ^ do_push;
        n_rd_ptr = r_rd_ptr ^ do_pop;
        n_count  = r_count + 2'(do_push) - 2'(do_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_code;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/mbp_back.sv
`default_nettype none

module mbp_back (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_empty,
    input  wire mbp_pkg::t_code i_code,
    output logic             o_pop,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [7:0]       o_out_byte,
    output logic             o_last_byte
);
    import mbp_pkg::*;

    logic             r_busy,  n_busy;
    logic             r_flush, n_flush;
    logic [CodeW-1:0] r_word,  n_word;
    logic [LenW-1:0]  r_rem,   n_rem;
    logic [7:0]       r_pbits, n_pbits;
    logic [2:0]       r_pcnt,  n_pcnt;
    logic             r_ovalid, n_ovalid;
    logic [7:0]       r_obyte,  n_obyte;
    logic             r_olast,  n_olast;

    logic             slot;
    logic [3:0]       need;
    logic [7:0]       cat;
    logic [LenW-1:0]  rem_left;

    assign slot     = !r_ovalid || !i_stall;
    assign o_pop    = !r_busy && !i_empty;
    assign need     = 4'd8 - {1'b0, r_pcnt};
    assign cat      = r_pbits | (r_word[CodeW-1 -: 8] >> r_pcnt);
    assign rem_left = r_rem - LenW'(need);

    always_comb begin
        n_busy   = r_busy;
        n_flush  = r_flush;
        n_word   = r_word;
        n_rem    = r_rem;
        n_pbits  = r_pbits;
        n_pcnt   = r_pcnt;
        n_ovalid = r_ovalid && i_stall;
        n_obyte  = r_obyte;
        n_olast  = r_olast;
        if (o_pop) begin
            n_busy  = 1'b1;
            n_flush = i_code.flush;
            n_word  = i_code.bits;
            n_rem   = i_code.len;
        end else if (r_busy && slot) begin
            if (r_flush) begin
                n_busy = 1'b0;
                if (r_pcnt != 3'd0) begin
                    n_ovalid = 1'b1;
                    n_obyte  = r_pbits;
                    n_olast  = 1'b1;
                end
                n_pbits = '0;
                n_pcnt  = '0;
            end else if (r_rem >= LenW'(need)) begin
                n_ovalid = 1'b1;
                n_obyte  = cat;
                n_olast  = (rem_left < LenW'(8));
                n_rem    = rem_left;
                n_word   = r_word << need;
                n_busy   = (rem_left != '0);
                n_pbits  = '0;
                n_pcnt   = '0;
            end else begin
                n_pbits = cat;
                n_pcnt  = r_pcnt + r_rem[2:0];
                n_busy  = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy   <= 1'b0;
            r_flush  <= 1'b0;
            r_rem    <= '0;
            r_pbits  <= '0;
            r_pcnt   <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_busy   <= n_busy;
            r_flush  <= n_flush;
            r_rem    <= n_rem;
            r_pbits  <= n_pbits;
            r_pcnt   <= n_pcnt;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_word  <= n_word;
        r_obyte <= n_obyte;
        r_olast <= n_olast;
    end

    assign o_valid     = r_ovalid;
    assign o_out_byte  = r_obyte;
    assign o_last_byte = r_olast;

endmodule

`default_nettype wire

FILE: rtl/msb_bit_packer_with_varlen_codes.sv
// MSB-first bit packer with raw, vluimsbf8 and vluimsbf4 codes.
// Input channel: i_valid / o_stall carry one item (i_op, i_value,
// i_bit_count); it is taken at a clock edge with i_valid high and o_stall low.
// Output channel: o_valid / i_stall carry one packed byte (o_out_byte,
// first written bit in bit 7) with o_last_byte marking the final byte
// that an item produces. An item that completes no byte gives no output.
// The front encodes an item combinationally into a two-entry queue; the back
// takes one queued code, then emits its output bytes (up to ten per item)
// and folds leftover bits into the partial byte. It takes no new code until
// it is through with the last one; the back byte loop sets the rate. The
// first byte passes the queue entry, the back's working word and the output
// register.
// A stalled output byte holds; the back then waits and the queue fills,
// after which o_stall rises. Synchronous reset clears the queue, the
// partial byte and the output register.
`default_nettype none

module msb_bit_packer_with_varlen_codes (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [1:0]  i_op,
    input  wire logic [63:0] i_value,
    input  wire logic [6:0]  i_bit_count,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [7:0]       o_out_byte,
    output logic             o_last_byte
);
    import mbp_pkg::*;

    t_code front_code;
    t_code queue_code;
    logic  queue_full;
    logic  queue_empty;
    logic  queue_pop;

    mbp_front u_front (
        .i_op        (i_op),
        .i_value     (i_value),
        .i_bit_count (i_bit_count),
        .o_code      (front_code)
    );

    mbp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (i_valid),
        .i_code  (front_code),
        .o_full  (queue_full),
        .i_pop   (queue_pop),
        .o_empty (queue_empty),
        .o_code  (queue_code)
    );

    mbp_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_empty     (queue_empty),
        .i_code      (queue_code),
        .o_pop       (queue_pop),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_out_byte  (o_out_byte),
        .o_last_byte (o_last_byte)
    );

    assign o_stall = queue_full;

endmodule

`default_nettype wire

FILE: verif/tb.sv
`default_nettype none

module tb;

    import mbp_pkg::*;

    class packed_byte_board;

        typedef struct {
            logic [7:0] data;
            logic       last;
        } t_byte_exp;

        logic [7:0] partial_bits;
        int         partial_count;
        logic [7:0] item_bytes[$];
        t_byte_exp  expected_bytes[$];
        int         mismatches;

        function new();
            partial_bits  = 8'h00;
            partial_count = 0;
            mismatches    = 0;
        endfunction

        function void push_bits(logic [63:0] v, int n);
            for (int i = n; i > 0; i--) begin
                partial_bits[7 - partial_count] = v[i-1];
                partial_count++;
                if (partial_count == 8) begin
                    item_bytes.push_back(partial_bits);
                    partial_bits  = 8'h00;
                    partial_count = 0;
                end
            end
        endfunction

        function void note_item(logic [1:0] op, logic [63:0] value,
                                logic [6:0] bit_count);
            int        groups;
            int        nibbles;
            t_byte_exp e;
            item_bytes.delete();
            case (op)
                OP_RAW: begin
                    push_bits(value, (bit_count > MaxRaw) ? MaxRaw : int'(bit_count));
                end
                OP_VLU8: begin
                    groups = 1;
                    while (groups < 10 && (value >> (7 * groups)) != 64'd0)
                        groups++;
                    for (int g = groups; g > 0; g--) begin
                        push_bits((g != 1) ? 64'd1 : 64'd0, 1);
                        push_bits((value >> (7 * (g - 1))) & 64'h7F, 7);
                    end
                end
                OP_VLU4: begin
                    nibbles = 1;
                    while (nibbles < 16 && (value >> (4 * nibbles)) != 64'd0)
                        nibbles++;
                    for (int k = 0; k + 1 < nibbles; k++)
                        push_bits(64'd1, 1);
                    push_bits(64'd0, 1);
                    push_bits(value, 4 * nibbles);
                end
                default: begin
                    if (partial_count > 0) begin
                        item_bytes.push_back(partial_bits);
                        partial_bits  = 8'h00;
                        partial_count = 0;
                    end
                end
            endcase
            foreach (item_bytes[i]) begin
                e.data = item_bytes[i];
                e.last = (i == item_bytes.size() - 1);
                expected_bytes.push_back(e);
            end
        endfunction

        function void check_byte(logic [7:0] data, logic last);
            t_byte_exp e;
            if (expected_bytes.size() == 0) begin
                $error("out_byte: expected none, actual %h", data);
                mismatches++;
            end else begin
                e = expected_bytes.pop_front();
                if (data !== e.data) begin
                    $error("out_byte: expected %h, actual %h", e.data, data);
                    mismatches++;
                end
                if (last !== e.last) begin
                    $error("last_byte: expected %b, actual %b", e.last, last);
                    mismatches++;
                end
            end
        endfunction

    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_stall;
    logic [1:0]  i_op;
    logic [63:0] i_value;
    logic [6:0]  i_bit_count;
    logic        o_valid;
    logic        i_stall;
    logic [7:0]  o_out_byte;
    logic        o_last_byte;

    packed_byte_board board = new();

    msb_bit_packer_with_varlen_codes u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_op        (i_op),
        .i_value     (i_value),
        .i_bit_count (i_bit_count),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_out_byte  (o_out_byte),
        .o_last_byte (o_last_byte)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #3_000_000;
        $display("msb_bit_packer_with_varlen_codes test failed");
        $finish;
    end

    task automatic send_item(input logic [1:0] op, input logic [63:0] value,
                             input logic [6:0] bit_count);
        i_valid     <= 1'b1;
        i_op        <= op;
        i_value     <= value;
        i_bit_count <= bit_count;
        do @(posedge i_clk); while (o_stall);
        board.note_item(op, value, bit_count);
    endtask

    task automatic idle_for(input int n);
        if (n > 0) begin
            i_valid <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
    endtask

    // receiver: check each taken byte, stall in randomly chosen modes
    initial begin
        int stall_mode;
        int mode_left;
        stall_mode = 0;
        mode_left  = 0;
        i_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_valid && !i_stall)
                board.check_byte(o_out_byte, o_last_byte);
            if (mode_left == 0) begin
                stall_mode = int'($urandom_range(0, 3));
                mode_left  = int'($urandom_range(16, 96));
            end
            mode_left--;
            case (stall_mode)
                0:       i_stall <= 1'b0;
                1:       i_stall <= ($urandom_range(0, 3) == 0);
                2:       i_stall <= ($urandom_range(0, 3) != 0);
                default: i_stall <= ~i_stall;
            endcase
        end
    end

    initial begin
        int          sent;
        int          burst;
        int          sel;
        logic [1:0]  op;
        logic [63:0] value;
        logic [6:0]  bit_count;

        i_rst_n     <= 1'b0;
        i_valid     <= 1'b0;
        i_op        <= OP_RAW;
        i_value     <= 64'd0;
        i_bit_count <= 7'd0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_item(OP_FLUSH, 64'd0, 7'd0);
        send_item(OP_RAW, 64'hFFFF_FFFF_FFFF_FFFF, 7'd0);
        send_item(OP_RAW, 64'd1, 7'd1);
        send_item(OP_RAW, 64'h7F, 7'd7);
        send_item(OP_RAW, 64'hFFFF_FFFF_FFFF_FFFF, 7'd64);
        idle_for(3);
        send_item(OP_RAW, 64'd0, 7'd64);
        send_item(OP_RAW, 64'hA5A5_A5A5_A5A5_A5A5, 7'd65);
        send_item(OP_RAW, 64'h0123_4567_89AB_CDEF, 7'd127);
        send_item(OP_RAW, 64'd5, 7'd3);
        send_item(OP_FLUSH, 64'hFFFF_FFFF_FFFF_FFFF, 7'h7F);
        send_item(OP_VLU8, 64'd0, 7'd0);
        send_item(OP_VLU8, 64'h7F, 7'd0);
        idle_for(2);
        send_item(OP_VLU8, 64'h80, 7'd0);
        send_item(OP_VLU8, 64'hFFFF_FFFF_FFFF_FFFF, 7'd0);
        send_item(OP_VLU8, 64'h8000_0000_0000_0000, 7'd0);
        send_item(OP_VLU4, 64'd0, 7'd0);
        send_item(OP_VLU4, 64'hF, 7'd0);
        send_item(OP_VLU4, 64'h10, 7'd0);
        send_item(OP_VLU4, 64'hFFFF_FFFF_FFFF_FFFF, 7'd0);
        send_item(OP_VLU4, 64'h1000_0000_0000_0000, 7'd0);
        send_item(OP_RAW, 64'h15, 7'd5);
        send_item(OP_VLU8, 64'h3_FFFF, 7'd0);
        send_item(OP_FLUSH, 64'd0, 7'd0);

        sent = 0;
        while (sent < 360) begin
            burst = int'($urandom_range(1, 30));
            repeat (burst) begin
                sel   = int'($urandom_range(0, 99));
                op    = (sel < 35) ? OP_RAW : (sel < 60) ? OP_VLU8 :
                        (sel < 88) ? OP_VLU4 : OP_FLUSH;
                value = {$urandom(), $urandom()};
                if ($urandom_range(0, 1) == 0)
                    value = value >> $urandom_range(0, 63);
                if ($urandom_range(0, 9) == 0)
                    bit_count = 7'($urandom_range(65, 127));
                else
                    bit_count = 7'($urandom_range(0, 64));
                send_item(op, value, bit_count);
                sent++;
            end
            if ($urandom_range(0, 2) != 0)
                idle_for(int'($urandom_range(1, 8)));
        end
        i_valid <= 1'b0;

        while (board.expected_bytes.size() != 0)
            @(posedge i_clk);
        repeat (30) @(posedge i_clk);

        if (board.mismatches == 0 && board.expected_bytes.size() == 0) begin
            $display("msb_bit_packer_with_varlen_codes test passed");
        end else begin
            $display("msb_bit_packer_with_varlen_codes test failed");
        end
        $finish;
    end

endmodule

`default_nettype wire

FILE: sim.f
rtl/mbp_pkg.sv
rtl/mbp_front.sv
rtl/mbp_queue.sv
rtl/mbp_back.sv
rtl/msb_bit_packer_with_varlen_codes.sv
verif/tb.sv
